// ----- rtl/pcts_pkg.sv -----
// ----------------------------------------------------------------------------
// pcts_pkg
// Types and fixed widths shared by the tone synthesizer modules.
// ----------------------------------------------------------------------------
package pcts_pkg;

   localparam int FREQ_W      = 12;
   localparam int DUR_W       = 25;
   localparam int RATE_W      = 17;
   localparam int PROD_W      = RATE_W + DUR_W;
   localparam int PHASE_W     = 32;
   localparam int NUM_W       = FREQ_W + PHASE_W;
   localparam int DIV_STEPS   = NUM_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int QB_W        = 33;
   localparam int HALF_W      = 20;
   localparam int MUL_STEPS   = 4;
   localparam int RECIP_SHIFT = 46;
   localparam int COUNT_W     = 16;
   localparam int SAMPLE_W    = 16;
   localparam int FIFO_DEPTH  = 2;
   localparam int FIFO_AW     = 1;
   localparam int FIFO_CNT_W  = 2;

   // ceil(2^46 / 125): floor(n / 125) = (n * RECIP_125) >> 46 for n below 2^39
   localparam logic [2*HALF_W-1:0] RECIP_125  = 40'd562949953422;
   localparam logic [RATE_W-1:0]   RATE_RESET = 17'd48000;

   typedef enum logic {
      OP_TONE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // one queued word: tone command or sample tick
   typedef struct packed {
      op_type              op;
      logic [FREQ_W-1:0]   freq;
      logic [RATE_W-1:0]   rate;
      logic [PROD_W-1:0]   prod;
   } item_type;

endpackage

// ----- rtl/pcts_front.sv -----
// ----------------------------------------------------------------------------
// pcts_front
// Input stage: takes request words, classifies them and forms queue entries.
// ----------------------------------------------------------------------------
module pcts_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [39:0]                       req_tdata,  // [11:0] frequency, [36:12] duration_ms_f16
   input  logic                              req_tuser,  // [0] func
   input  logic [pcts_pkg::RATE_W-1:0]       rate,
   output logic                              push_valid,
   input  logic                              push_ready,
   output pcts_pkg::item_type                push_item
);
   import pcts_pkg::*;

   logic              hold_valid_ff, hold_valid_in;
   op_type            hold_op_ff, hold_op_in;
   logic [FREQ_W-1:0] hold_freq_ff, hold_freq_in;
   logic [DUR_W-1:0]  hold_dur_ff, hold_dur_in;
   logic              accept;
   logic              push;

   assign push       = hold_valid_ff && push_ready;
   assign req_tready = !hold_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = hold_valid_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_op_in    = hold_op_ff;
      hold_freq_in  = hold_freq_ff;
      hold_dur_in   = hold_dur_ff;
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_op_in    = req_tuser ? OP_TICK : OP_TONE;
         hold_freq_in  = req_tdata[FREQ_W-1:0];
         hold_dur_in   = req_tdata[FREQ_W+DUR_W-1:FREQ_W];
      end
   end

   // rate*duration goes into the queue so the back end only divides
   always_comb begin
      push_item.op   = hold_op_ff;
      push_item.freq = hold_freq_ff;
      push_item.rate = rate;
      push_item.prod = PROD_W'(rate) * PROD_W'(hold_dur_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_op_ff   <= hold_op_in;
      hold_freq_ff <= hold_freq_in;
      hold_dur_ff  <= hold_dur_in;
   end

endmodule

// ----- rtl/pcts_fifo.sv -----
// ----------------------------------------------------------------------------
// pcts_fifo
// Short queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module pcts_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  pcts_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop,
   output pcts_pkg::item_type pop_item
);
   import pcts_pkg::*;

   item_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = count_ff != FIFO_CNT_W'(FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/pcts_div.sv -----
// ----------------------------------------------------------------------------
// pcts_div
// Restoring divider, one bit per cycle, for (freq << 32) / rate, and a
// reciprocal multiply for (rate*duration) / 1000 over its first four steps.
// ----------------------------------------------------------------------------
module pcts_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  pcts_pkg::item_type           item,
   output logic                         done,
   output logic [pcts_pkg::PHASE_W-1:0] quo_step,
   output logic [pcts_pkg::QB_W-1:0]    quo_count
);
   import pcts_pkg::*;

   localparam int NB_W  = 2 * HALF_W;
   localparam int ACC_W = 4 * HALF_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     num_a_ff, num_a_in;
   logic [RATE_W-1:0]    den_a_ff, den_a_in;
   logic [RATE_W-1:0]    rem_a_ff, rem_a_in;
   logic [PHASE_W-1:0]   q_a_ff, q_a_in;
   logic [NB_W-1:0]      n_b_ff, n_b_in;
   logic [ACC_W-1:0]     acc_b_ff, acc_b_in;
   logic [RATE_W:0]      rem_a_sh, diff_a;
   logic                 ge_a;
   logic [HALF_W-1:0]    mul_x, mul_y;
   logic [NB_W-1:0]      mul_p;
   logic [ACC_W-1:0]     mul_sh;

   assign rem_a_sh = {rem_a_ff, num_a_ff[NUM_W-1]};
   assign diff_a   = rem_a_sh - {1'b0, den_a_ff};
   assign ge_a     = rem_a_sh >= {1'b0, den_a_ff};

   // x/1000 = (x >> 3) / 125; one 20x20 partial product per step
   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin
            mul_x = n_b_ff[HALF_W-1:0];
            mul_y = RECIP_125[HALF_W-1:0];
         end
         2'd1: begin
            mul_x = n_b_ff[HALF_W-1:0];
            mul_y = RECIP_125[NB_W-1:HALF_W];
         end
         2'd2: begin
            mul_x = n_b_ff[NB_W-1:HALF_W];
            mul_y = RECIP_125[HALF_W-1:0];
         end
         default: begin
            mul_x = n_b_ff[NB_W-1:HALF_W];
            mul_y = RECIP_125[NB_W-1:HALF_W];
         end
      endcase
   end

   assign mul_p = mul_x * mul_y;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:       mul_sh = {{NB_W{1'b0}}, mul_p};
         2'd1, 2'd2: mul_sh = {{HALF_W{1'b0}}, mul_p, {HALF_W{1'b0}}};
         default:    mul_sh = {mul_p, {NB_W{1'b0}}};
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      num_a_in = num_a_ff;
      den_a_in = den_a_ff;
      rem_a_in = rem_a_ff;
      q_a_in   = q_a_ff;
      n_b_in   = n_b_ff;
      acc_b_in = acc_b_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         num_a_in = {item.freq, {PHASE_W{1'b0}}};
         den_a_in = item.rate;
         rem_a_in = '0;
         q_a_in   = '0;
         n_b_in   = NB_W'(item.prod[PROD_W-1:3]);
         acc_b_in = '0;
      end else if (busy_ff) begin
         num_a_in = num_a_ff << 1;
         rem_a_in = ge_a ? diff_a[RATE_W-1:0] : rem_a_sh[RATE_W-1:0];
         q_a_in   = {q_a_ff[PHASE_W-2:0], ge_a};
         if (cnt_ff < DIV_CNT_W'(MUL_STEPS)) begin
            acc_b_in = acc_b_ff + mul_sh;
         end
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      num_a_ff <= num_a_in;
      den_a_ff <= den_a_in;
      rem_a_ff <= rem_a_in;
      q_a_ff   <= q_a_in;
      n_b_ff   <= n_b_in;
      acc_b_ff <= acc_b_in;
   end

   assign done      = done_ff;
   assign quo_step  = q_a_ff;
   assign quo_count = acc_b_ff[RECIP_SHIFT +: QB_W];

endmodule

// ----- rtl/pcts_back.sv -----
// ----------------------------------------------------------------------------
// pcts_back
// Execution side: loads tone commands through the divider, runs the phase
// accumulator, reads the sine ROM and holds the result word.
// ----------------------------------------------------------------------------
module pcts_back #(
   parameter int SINE_ROM_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fifo_valid,
   output logic                          fifo_pop,
   input  pcts_pkg::item_type            fifo_item,
   output logic                          div_start,
   input  logic                          div_done,
   input  logic [pcts_pkg::PHASE_W-1:0]  quo_step,
   input  logic [pcts_pkg::QB_W-1:0]     quo_count,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,  // [15:0] sample
   output logic                          rsp_tlast   // tone_done
);
   import pcts_pkg::*;

   localparam int AW = $clog2(SINE_ROM_DEPTH);
   localparam int PW = PHASE_W + AW;
   localparam int EXACT_W = QB_W + 1;
   localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

   typedef logic signed [SAMPLE_W-1:0] rom_type [SINE_ROM_DEPTH];

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_ROM  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   // (a*b) >> 60 with the full product
   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // Taylor series of sin in Q60, x in [0, pi/2]
   function automatic logic [63:0] sine_q60(input logic [63:0] x);
      logic [63:0] x2, term, sum;
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= 14; n++) begin
         term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   function automatic rom_type build_rom();
      rom_type     tbl;
      logic [63:0] q, r, k, t, x, s40, mag, d;
      logic        neg;
      d = 64'(SINE_ROM_DEPTH);
      q = HALF_PI_Q60 / SINE_ROM_DEPTH;
      r = HALF_PI_Q60 % SINE_ROM_DEPTH;
      for (int i = 0; i < SINE_ROM_DEPTH; i++) begin
         k   = 64'(4 * i);
         neg = 1'b0;
         if (k <= d) begin
            t = k;
         end else if (k <= 2 * d) begin
            t = 2 * d - k;
         end else if (k <= 3 * d) begin
            t   = k - 2 * d;
            neg = 1'b1;
         end else begin
            t   = 4 * d - k;
            neg = 1'b1;
         end
         x   = q * t + (r * t) / SINE_ROM_DEPTH;
         s40 = sine_q60(x) >> 20;
         mag = (s40 * 64'd32767 + (64'd1 << 39)) >> 40;
         if (mag > 64'd32767) begin
            mag = 64'd32767;
         end
         tbl[i] = neg ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
      end
      return tbl;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   state_type            state_ff, state_in;
   logic [PHASE_W-1:0]   phase_acc_ff, phase_acc_in;
   logic [PHASE_W-1:0]   phase_step_ff, phase_step_in;
   logic [COUNT_W-1:0]   residue_ff, residue_in;
   logic [COUNT_W-1:0]   samples_left_ff, samples_left_in;
   logic                 rate_zero_ff, rate_zero_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 last_ff, last_in;
   logic [SAMPLE_W-1:0]  rom_q_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic                 tone_done_ff, tone_done_in;
   logic [PW-1:0]        phase_prod;
   logic [EXACT_W-1:0]   exact;
   logic                 slot_free;

   // ROM index = (phase * depth) >> 32
   assign phase_prod = PW'(phase_acc_ff) * PW'(SINE_ROM_DEPTH);
   assign exact      = EXACT_W'(quo_count) + EXACT_W'(residue_ff);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in        = state_ff;
      phase_acc_in    = phase_acc_ff;
      phase_step_in   = phase_step_ff;
      residue_in      = residue_ff;
      samples_left_in = samples_left_ff;
      rate_zero_in    = rate_zero_ff;
      addr_in         = addr_ff;
      last_in         = last_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      sample_in       = sample_ff;
      tone_done_in    = tone_done_ff;
      fifo_pop        = 1'b0;
      div_start       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (fifo_valid) begin
               fifo_pop = 1'b1;
               if (fifo_item.op == OP_TONE) begin
                  div_start    = 1'b1;
                  rate_zero_in = fifo_item.rate == '0;
                  state_in     = ST_DIV;
               end else if (samples_left_ff != '0) begin
                  addr_in         = phase_prod[PW-1:PHASE_W];
                  phase_acc_in    = phase_acc_ff + phase_step_ff;
                  samples_left_in = samples_left_ff - 1'b1;
                  last_in         = samples_left_ff == COUNT_W'(1);
                  state_in        = ST_ROM;
               end
               // tick with nothing pending: dropped
            end
         end
         ST_DIV: begin
            if (div_done) begin
               phase_step_in = rate_zero_ff ? '0 : quo_step;
               residue_in    = exact[COUNT_W-1:0];
               // count saturates, residue keeps the exact low bits
               if (exact[EXACT_W-1:2*COUNT_W] != '0) begin
                  samples_left_in = '1;
               end else begin
                  samples_left_in = exact[2*COUNT_W-1:COUNT_W];
               end
               state_in = ST_IDLE;
            end
         end
         ST_ROM: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               sample_in    = rom_q_ff;
               tone_done_in = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         phase_acc_ff    <= '0;
         phase_step_ff   <= '0;
         residue_ff      <= '0;
         samples_left_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_acc_ff    <= phase_acc_in;
         phase_step_ff   <= phase_step_in;
         residue_ff      <= residue_in;
         samples_left_ff <= samples_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rate_zero_ff <= rate_zero_in;
      addr_ff      <= addr_in;
      last_ff      <= last_in;
      rom_q_ff     <= SINE_ROM[addr_ff];
      sample_ff    <= sample_in;
      tone_done_ff <= tone_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sample_ff;
   assign rsp_tlast  = tone_done_ff;

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside a command load");

   a_rom_after_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROM |-> $past(state_ff) == ST_IDLE)
      else $error("ROM read without a tick issue");

   a_last_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free && last_ff) |-> samples_left_ff == '0)
      else $error("tone_done flagged with samples still left");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free) |=> rsp_valid_ff)
      else $error("sample not loaded into output register");

endmodule

// ----- rtl/phase_continuous_tone_synth.sv -----
// ----------------------------------------------------------------------------
// phase_continuous_tone_synth
// NCO tone generator with sine ROM, phase kept across tones.
//
//   port group  dir  handshake         carries
//   req_*       in   tvalid/tready     tone command or sample tick
//   rsp_*       out  tvalid/tready     sine sample, tlast on last of tone
//   csr_*       in   psel/penable      sample_rate_hz at offset 0
//
// A tick takes the back end from the queue head through ST_IDLE, ST_ROM and
// ST_EMIT, which puts the word on rsp_* once the output register is free.
// A tone command holds it in ST_DIV until the 44-step bit-serial phase step
// divider is done; a reciprocal multiply gives the sample count meanwhile.
// Synchronous reset; no clearing pass, the ROM is constant.
// The front stage and 2-entry queue keep accepting words while the back
// end divides or waits on rsp_tready.
// ----------------------------------------------------------------------------
module phase_continuous_tone_synth #(
   parameter int SINE_ROM_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [11:0] frequency, [36:12] duration_ms_f16
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample
   output logic        rsp_tlast,   // tone_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pcts_pkg::*;

   localparam logic REG_IDX_RATE = 1'b0;

   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic               csr_wr;
   logic               push_valid;
   logic               push_ready;
   item_type           push_item;
   logic               pop_valid;
   logic               pop;
   item_type           pop_item;
   logic               div_start;
   logic               div_done;
   logic [PHASE_W-1:0] quo_step;
   logic [QB_W-1:0]    quo_count;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_IDX_RATE) ? 32'(rate_ff) : '0;

   always_comb begin
      rate_in = rate_ff;
      if (csr_wr && csr_paddr[2] == REG_IDX_RATE) begin
         rate_in = csr_pwdata[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else begin
         rate_ff <= rate_in;
      end
   end

   pcts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rate       (rate_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   pcts_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   pcts_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .item      (pop_item),
      .done      (div_done),
      .quo_step  (quo_step),
      .quo_count (quo_count)
   );

   pcts_back #(
      .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_valid (pop_valid),
      .fifo_pop   (pop),
      .fifo_item  (pop_item),
      .div_start  (div_start),
      .div_done   (div_done),
      .quo_step   (quo_step),
      .quo_count  (quo_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- tb/sv/tone_synth_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tone_synth_checker
// Watches the request, sample and register ports of the tone synthesizer,
// tracks NCO phase, step, sample count and count residue on every accepted
// word, and compares each sample word against the oldest predicted sample.
// ----------------------------------------------------------------------------
module tone_synth_checker #(
   parameter logic [2:0] RATE_ADDR = 3'd0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          errors,
   output int          pending,
   output int          samples_checked
);
   import pcts_pkg::*;

   localparam int          SINE_DEPTH  = 1024;
   localparam int          LUT_AW      = $clog2(SINE_DEPTH);
   localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } tone_sample_type;

   tone_sample_type            expected_samples[$];
   logic signed [SAMPLE_W-1:0] sine_lut [SINE_DEPTH];

   logic [RATE_W-1:0]  rate;
   logic [PHASE_W-1:0] nco_phase;
   logic [PHASE_W-1:0] phase_step;
   logic [15:0]        count_residue;
   logic [COUNT_W-1:0] tone_remaining;

   // (a * b) >> 60 on the full 128-bit product
   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // quarter-wave mirrored sine, Taylor series in Q60, round half away from zero
   initial begin : fill_sine
      logic [63:0] step_q, step_r, k, t, angle, angle_sq, term, sum, s40, mag;
      logic        neg;
      step_q = HALF_PI_Q60 / SINE_DEPTH;
      step_r = HALF_PI_Q60 % SINE_DEPTH;
      for (int i = 0; i < SINE_DEPTH; i++) begin
         k   = 64'(4 * i);
         neg = 1'b0;
         if (k <= SINE_DEPTH) begin
            t = k;
         end else if (k <= 2 * SINE_DEPTH) begin
            t = 2 * SINE_DEPTH - k;
         end else if (k <= 3 * SINE_DEPTH) begin
            t   = k - 2 * SINE_DEPTH;
            neg = 1'b1;
         end else begin
            t   = 4 * SINE_DEPTH - k;
            neg = 1'b1;
         end
         angle    = step_q * t + (step_r * t) / SINE_DEPTH;
         angle_sq = q60_mul(angle, angle);
         term     = angle;
         sum      = angle;
         for (int n = 1; n <= 14; n++) begin
            term = q60_mul(term, angle_sq) / 64'((2 * n) * (2 * n + 1));
            if (n % 2) sum = sum - term;
            else       sum = sum + term;
         end
         s40 = sum >> 20;
         mag = (s40 * 64'd32767 + (64'd1 << 39)) >> 40;
         if (mag > 64'd32767) mag = 64'd32767;
         sine_lut[i] = neg ? -16'(mag) : 16'(mag);
      end
   end

   always @(posedge clock) begin : watch
      tone_sample_type     want;
      logic [63:0]         quotient, exact_count;
      logic [FREQ_W-1:0]   freq;
      logic [DUR_W-1:0]    dur;
      if (reset) begin
         rate            = RATE_RESET;
         nco_phase       = '0;
         phase_step      = '0;
         count_residue   = '0;
         tone_remaining  = '0;
         errors          = 0;
         samples_checked = 0;
         expected_samples.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == RATE_ADDR)
            rate = csr_pwdata[RATE_W-1:0];

         // retire before predicting: a word accepted now cannot come out on the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               errors++;
               $error("sample word with none expected: sample %0d, tone_done %0b",
                      $signed(rsp_tdata), rsp_tlast);
            end else begin
               want = expected_samples.pop_front();
               samples_checked++;
               if (rsp_tdata !== want.sample) begin
                  errors++;
                  $error("sample: expected %0d, actual %0d", want.sample, $signed(rsp_tdata));
               end
               if (rsp_tlast !== want.last) begin
                  errors++;
                  $error("tone_done: expected %0b, actual %0b", want.last, rsp_tlast);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            freq = req_tdata[FREQ_W-1:0];
            dur  = req_tdata[FREQ_W +: DUR_W];
            if (op_type'(req_tuser) == OP_TONE) begin
               if (rate == '0) begin
                  phase_step = '0;
               end else begin
                  quotient   = 64'({freq, 32'h0}) / 64'(rate);
                  phase_step = quotient[PHASE_W-1:0];
               end
               exact_count    = 64'(rate) * 64'(dur) / 64'd1000 + 64'(count_residue);
               tone_remaining = (exact_count[63:16] > 48'hFFFF) ? 16'hFFFF : exact_count[31:16];
               count_residue  = exact_count[15:0];
            end else if (tone_remaining != '0) begin
               want.sample    = sine_lut[nco_phase[PHASE_W-1 -: LUT_AW]];
               nco_phase      = nco_phase + phase_step;
               tone_remaining = tone_remaining - 1'b1;
               want.last      = (tone_remaining == '0);
               expected_samples.push_back(want);
            end
         end
      end
      pending = expected_samples.size();
   end

endmodule

// ----- tb/sv/tb_phase_continuous_tone_synth.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_phase_continuous_tone_synth
// Drives tone commands and sample ticks into the tone synthesizer with
// random gaps and output stalls, changes the sample rate between phases,
// and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_phase_continuous_tone_synth;
   import pcts_pkg::*;

   localparam logic [2:0] RATE_ADDR     = 3'd0;
   localparam int         SETTLE_CYCLES = 250;
   localparam int         RUN_LIMIT     = 300000;
   localparam int         RANDOM_WORDS  = 600;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int errors, pending, samples_checked;
   int send_idle     = 0;
   int recv_idle     = 0;
   int cycle_count   = 0;
   int tone_words    = 0;
   int tick_words    = 0;
   int rate_settings = 1;
   int unsigned current_rate = RATE_RESET;

   phase_continuous_tone_synth uut (.*);

   tone_synth_checker #(.RATE_ADDR(RATE_ADDR)) u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .errors, .pending, .samples_checked
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d samples still expected", cycle_count, pending);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // returns at the edge that accepted the word; tvalid stays high
   task automatic send_word(input op_type op, input logic [FREQ_W-1:0] freq,
                            input logic [DUR_W-1:0] dur);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, dur, freq};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_TONE) tone_words++;
      else               tick_words++;
   endtask

   task automatic send_tick();
      send_word(OP_TICK, 12'($urandom), 25'($urandom));
   endtask

   // hold off until every predicted sample is out and the divider is done
   task automatic settle_synth();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sample_rate(input logic [RATE_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= RATE_ADDR;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      current_rate = value;
      rate_settings++;
   endtask

   initial begin
      logic [DUR_W-1:0] dur;
      int               target;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle tick, zero-length tone, tone replaced mid-way
      send_tick();
      send_word(OP_TONE, 12'd0, 25'd0);
      send_tick();
      send_word(OP_TONE, 12'd4095, 25'd16384);
      repeat (4) send_tick();
      send_word(OP_TONE, 12'd1000, 25'd3000);
      repeat (3) send_tick();

      // zero rate: no step, no samples
      settle_synth();
      write_sample_rate(17'd0);
      send_word(OP_TONE, 12'd440, 25'h1FFFFFF);
      send_tick();

      // top rate with longest duration saturates the count
      settle_synth();
      write_sample_rate(17'h1FFFF);
      send_word(OP_TONE, 12'd4095, 25'h1FFFFFF);
      repeat (2) send_tick();
      send_word(OP_TONE, 12'd1, 25'd1);
      send_tick();

      // frequency above rate wraps the step; rate change keeps the loaded step
      settle_synth();
      write_sample_rate(17'd1000);
      send_word(OP_TONE, 12'd4095, 25'd200000);
      repeat (2) send_tick();
      settle_synth();
      write_sample_rate(17'd96000);
      repeat (2) send_tick();

      target = tone_words + tick_words;
      for (int p = 0; p < 3; p++) begin
         case (p)
            0:       begin send_idle = 29; recv_idle = 49; end
            1:       begin send_idle = 49; recv_idle = 29; end
            default: begin send_idle = 0;  recv_idle = 0;  end
         endcase
         for (int b = 0; b < 2; b++) begin
            settle_synth();
            case (p * 2 + b)
               0:       write_sample_rate(17'd8192);
               1:       write_sample_rate(17'd96000);
               2:       write_sample_rate(17'd48000);
               default: write_sample_rate(17'($urandom_range(8192, 96000)));
            endcase
            target += RANDOM_WORDS / 6;
            while (tone_words + tick_words < target) begin
               if ($urandom_range(0, 99) < 85) begin
                  // well-formed: a short tone followed by a run of ticks
                  if ($urandom_range(0, 19) == 0)
                     dur = 25'($urandom);
                  else
                     dur = 25'($urandom_range(0, 1300000000 / current_rate));
                  send_word(OP_TONE, 12'($urandom), dur);
                  repeat ($urandom_range(0, 24)) send_tick();
               end else begin
                  send_word(op_type'($urandom_range(0, 1)), 12'($urandom), 25'($urandom));
               end
            end
         end
      end

      settle_synth();
      $display("covered %0d tone commands and %0d sample ticks at %0d rate settings",
               tone_words, tick_words, rate_settings);
      $display("%0d sine samples checked against prediction", samples_checked);
      if (errors == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
